// ----- rtl/ffls_pkg.sv -----
// shared widths, types and register codes for the flat lambert shader
// no dependencies
`default_nettype none
package ffls_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int LIGHT_WIDTH = 16;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int NRM_W       = PROD_W + 1;
	localparam int NSQ_W       = 2 * NRM_W;
	localparam int N2_W        = NSQ_W + 2;
	localparam int L2_W        = 2 * LIGHT_WIDTH;
	localparam int L2_LO       = L2_W / 2;
	localparam int L2_HI       = L2_W - L2_LO;
	localparam int DP_W        = N2_W + L2_HI;
	localparam int NL_W        = NRM_W + LIGHT_WIDTH;
	localparam int DOT_W       = NL_W + 2;
	localparam int LEVEL_W     = 8;
	localparam int LEVEL_MAX   = (1 << LEVEL_W) - 1;
	localparam int ROOT_W      = DOT_W - 1 + LEVEL_W;
	localparam int ROOT_LO     = ROOT_W / 2;
	localparam int ROOT_HI     = ROOT_W - ROOT_LO;
	localparam int NUM_W       = 2 * ROOT_W;
	localparam int DEN_W       = N2_W + L2_W;
	localparam int SRCH_W      = NUM_W + 2;
	localparam int SRCH_STEPS  = LEVEL_W;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 4;

	typedef enum logic [1:0] {
		REG_LIGHT_X = 2'd0,
		REG_LIGHT_Y = 2'd1,
		REG_LIGHT_Z = 2'd2
	} reg_idx_t;

	localparam logic signed [LIGHT_WIDTH-1:0] LIGHT_X_RST = LIGHT_WIDTH'(0);
	localparam logic signed [LIGHT_WIDTH-1:0] LIGHT_Y_RST = LIGHT_WIDTH'(0);
	localparam logic signed [LIGHT_WIDTH-1:0] LIGHT_Z_RST = LIGHT_WIDTH'(16384);

	typedef struct packed {
		logic signed [LIGHT_WIDTH-1:0] x;
		logic signed [LIGHT_WIDTH-1:0] y;
		logic signed [LIGHT_WIDTH-1:0] z;
		logic        [L2_W-1:0]        len2;
	} light_t;

	typedef struct packed {
		logic deg;
		logic away;
	} flags_t;
endpackage
`default_nettype wire

// ----- rtl/ffls_tri_if.sv -----
// triangle input channel: valid, ready and nine vertex coordinates
// depends on ffls_pkg
`default_nettype none
interface ffls_tri_if;
	logic valid;
	logic ready;
	logic signed [ffls_pkg::COORD_WIDTH-1:0] v0_x, v0_y, v0_z;
	logic signed [ffls_pkg::COORD_WIDTH-1:0] v1_x, v1_y, v1_z;
	logic signed [ffls_pkg::COORD_WIDTH-1:0] v2_x, v2_y, v2_z;
	modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, input ready);
	modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, output ready);
endinterface
`default_nettype wire

// ----- rtl/ffls_shade_if.sv -----
// shade result channel: valid, ready, level and flags
// depends on ffls_pkg
`default_nettype none
interface ffls_shade_if;
	logic valid;
	logic ready;
	logic [ffls_pkg::LEVEL_W-1:0] shade_level;
	logic faces_away;
	logic degenerate;
	modport source (output valid, shade_level, faces_away, degenerate, input ready);
	modport sink (input valid, shade_level, faces_away, degenerate, output ready);
endinterface
`default_nettype wire

// ----- rtl/ffls_apb_regs.sv -----
// apb register file for the light direction, also keeps its squared length
// depends on ffls_pkg
`default_nettype none
module ffls_apb_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [ffls_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [ffls_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [ffls_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	output ffls_pkg::light_t                       light
);
	logic signed [ffls_pkg::LIGHT_WIDTH-1:0] x_q, y_q, z_q;
	logic [ffls_pkg::L2_W-1:0] len2_q;
	logic signed [ffls_pkg::L2_W-1:0] sx, sy, sz;
	ffls_pkg::reg_idx_t idx;
	logic wr;

	assign pready = 1'b1;
	assign idx = ffls_pkg::reg_idx_t'(paddr[3:2]);
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= ffls_pkg::LIGHT_X_RST;
			y_q <= ffls_pkg::LIGHT_Y_RST;
			z_q <= ffls_pkg::LIGHT_Z_RST;
		end else if (wr) begin
			unique case (idx)
				ffls_pkg::REG_LIGHT_X: x_q <= pwdata[ffls_pkg::LIGHT_WIDTH-1:0];
				ffls_pkg::REG_LIGHT_Y: y_q <= pwdata[ffls_pkg::LIGHT_WIDTH-1:0];
				ffls_pkg::REG_LIGHT_Z: z_q <= pwdata[ffls_pkg::LIGHT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sx = x_q * x_q;
		sy = y_q * y_q;
		sz = z_q * z_q;
	end

	// squared length follows the registers in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len2_q <= '0;
		end else begin
			len2_q <= $unsigned(sx) + $unsigned(sy) + $unsigned(sz);
		end
	end

	always_comb begin
		unique case (idx)
			ffls_pkg::REG_LIGHT_X: prdata = ffls_pkg::APB_DATA_W'($unsigned(x_q));
			ffls_pkg::REG_LIGHT_Y: prdata = ffls_pkg::APB_DATA_W'($unsigned(y_q));
			ffls_pkg::REG_LIGHT_Z: prdata = ffls_pkg::APB_DATA_W'($unsigned(z_q));
			default: prdata = '0;
		endcase
	end

	assign light.x = x_q;
	assign light.y = y_q;
	assign light.z = z_q;
	assign light.len2 = len2_q;
endmodule
`default_nettype wire

// ----- rtl/flat_face_lambert_shade.sv -----
// top level of the flat lambert shader: pipeline from vertices to grey level
// depends on ffls_pkg, ffls_tri_if, ffls_shade_if, ffls_apb_regs
//
// One triangle enters per clock while the output is taken, and its grey level
// leaves from the last search stage. The pipeline forms edge vectors, the face
// normal, the squared normal length and n.L, then the squared numerator and
// denominator, and finds the level exactly by an 8-step binary search, one
// stage per result bit, using only shifts, a three-input add, a compare and
// one running-sum add per stage. The whole pipeline holds while a result
// waits, so sustained rate is one triangle per cycle when the output is taken.
// Light registers are to be written over APB only while the pipeline is empty;
// the block does not enforce it. The squared light length is ready the next cycle.
`default_nettype none
module flat_face_lambert_shade (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	ffls_tri_if.sink                              face,
	ffls_shade_if.source                          shade,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [ffls_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [ffls_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [ffls_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready
);
	localparam int S = ffls_pkg::SRCH_STEPS;

	ffls_pkg::light_t light;
	logic adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [ffls_pkg::DIFF_W-1:0] a_s1 [3];
	logic signed [ffls_pkg::DIFF_W-1:0] b_s1 [3];
	logic signed [ffls_pkg::NRM_W-1:0] n_s2 [3];
	logic [ffls_pkg::N2_W-1:0] n2_s3;
	logic signed [ffls_pkg::DOT_W-1:0] dot_s3;
	ffls_pkg::flags_t fl_s4, fl_s5;
	logic [ffls_pkg::ROOT_W-1:0] root_s4;
	logic [ffls_pkg::DP_W-1:0] dlo_s4, dhi_s4;
	logic [ffls_pkg::DEN_W-1:0] den_s5;
	logic [2*ffls_pkg::ROOT_HI-1:0] hh_s5;
	logic [ffls_pkg::ROOT_HI+ffls_pkg::ROOT_LO-1:0] hl_s5;
	logic [2*ffls_pkg::ROOT_LO-1:0] ll_s5;

	// search stages: index 0 is stage 6, index S is the output stage
	logic vld_sr [S+1];
	ffls_pkg::flags_t fl_sr [S+1];
	logic [ffls_pkg::NUM_W-1:0] num_sr [S+1];
	logic [ffls_pkg::DEN_W-1:0] den_sr [S+1];
	logic [ffls_pkg::SRCH_W-1:0] p_sr [S+1];
	logic [ffls_pkg::SRCH_W-1:0] q_sr [S+1];
	logic [ffls_pkg::LEVEL_W-1:0] lvl_sr [S+1];

	logic signed [ffls_pkg::PROD_W-1:0] pr [6];
	logic signed [ffls_pkg::NSQ_W-1:0] sq [3];
	logic signed [ffls_pkg::NL_W-1:0] nl [3];
	logic [ffls_pkg::SRCH_W-1:0] cand [S];
	logic [ffls_pkg::SRCH_W-1:0] dsh [S];
	logic take [S];

	ffls_apb_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .light(light)
	);

	assign adv = !vld_sr[S] || shade.ready;
	assign face.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			for (int i = 0; i <= S; i++) vld_sr[i] <= 1'b0;
		end else if (adv) begin
			vld_s1 <= face.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_sr[0] <= vld_s5;
			for (int i = 0; i < S; i++) vld_sr[i+1] <= vld_sr[i];
		end
	end

	always_comb begin
		pr[0] = a_s1[1] * b_s1[2];
		pr[1] = a_s1[2] * b_s1[1];
		pr[2] = a_s1[2] * b_s1[0];
		pr[3] = a_s1[0] * b_s1[2];
		pr[4] = a_s1[0] * b_s1[1];
		pr[5] = a_s1[1] * b_s1[0];
		for (int i = 0; i < 3; i++) sq[i] = n_s2[i] * n_s2[i];
		nl[0] = n_s2[0] * light.x;
		nl[1] = n_s2[1] * light.y;
		nl[2] = n_s2[2] * light.z;
	end

	// one exact search step per stage
	always_comb begin
		for (int j = 0; j < S; j++) begin
			dsh[j] = ffls_pkg::SRCH_W'(den_sr[j]) << (S - 1 - j);
			cand[j] = p_sr[j] + (q_sr[j] << (S - j))
				+ (ffls_pkg::SRCH_W'(den_sr[j]) << (2 * (S - 1 - j)));
			take[j] = cand[j] <= ffls_pkg::SRCH_W'(num_sr[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1[0] <= ffls_pkg::DIFF_W'(face.v0_x) - ffls_pkg::DIFF_W'(face.v1_x);
			a_s1[1] <= ffls_pkg::DIFF_W'(face.v0_y) - ffls_pkg::DIFF_W'(face.v1_y);
			a_s1[2] <= ffls_pkg::DIFF_W'(face.v0_z) - ffls_pkg::DIFF_W'(face.v1_z);
			b_s1[0] <= ffls_pkg::DIFF_W'(face.v2_x) - ffls_pkg::DIFF_W'(face.v1_x);
			b_s1[1] <= ffls_pkg::DIFF_W'(face.v2_y) - ffls_pkg::DIFF_W'(face.v1_y);
			b_s1[2] <= ffls_pkg::DIFF_W'(face.v2_z) - ffls_pkg::DIFF_W'(face.v1_z);

			n_s2[0] <= ffls_pkg::NRM_W'(pr[0]) - ffls_pkg::NRM_W'(pr[1]);
			n_s2[1] <= ffls_pkg::NRM_W'(pr[2]) - ffls_pkg::NRM_W'(pr[3]);
			n_s2[2] <= ffls_pkg::NRM_W'(pr[4]) - ffls_pkg::NRM_W'(pr[5]);

			n2_s3 <= ffls_pkg::N2_W'($unsigned(sq[0])) + ffls_pkg::N2_W'($unsigned(sq[1]))
				+ ffls_pkg::N2_W'($unsigned(sq[2]));
			dot_s3 <= ffls_pkg::DOT_W'(nl[0]) + ffls_pkg::DOT_W'(nl[1])
				+ ffls_pkg::DOT_W'(nl[2]);

			fl_s4.deg <= (n2_s3 == '0) || (light.len2 == '0);
			fl_s4.away <= dot_s3[ffls_pkg::DOT_W-1] && (n2_s3 != '0)
				&& (light.len2 != '0);
			root_s4 <= ffls_pkg::ROOT_W'($unsigned(dot_s3[ffls_pkg::DOT_W-2:0]))
				* ffls_pkg::ROOT_W'(ffls_pkg::LEVEL_MAX);
			dlo_s4 <= ffls_pkg::DP_W'(n2_s3)
				* ffls_pkg::DP_W'(light.len2[ffls_pkg::L2_LO-1:0]);
			dhi_s4 <= ffls_pkg::DP_W'(n2_s3)
				* ffls_pkg::DP_W'(light.len2[ffls_pkg::L2_W-1:ffls_pkg::L2_LO]);

			fl_s5 <= fl_s4;
			den_s5 <= ffls_pkg::DEN_W'(dlo_s4)
				+ (ffls_pkg::DEN_W'(dhi_s4) << ffls_pkg::L2_LO);
			hh_s5 <= root_s4[ffls_pkg::ROOT_W-1:ffls_pkg::ROOT_LO]
				* root_s4[ffls_pkg::ROOT_W-1:ffls_pkg::ROOT_LO];
			hl_s5 <= root_s4[ffls_pkg::ROOT_W-1:ffls_pkg::ROOT_LO]
				* root_s4[ffls_pkg::ROOT_LO-1:0];
			ll_s5 <= root_s4[ffls_pkg::ROOT_LO-1:0] * root_s4[ffls_pkg::ROOT_LO-1:0];

			fl_sr[0] <= fl_s5;
			den_sr[0] <= den_s5;
			num_sr[0] <= (ffls_pkg::NUM_W'(hh_s5) << (2 * ffls_pkg::ROOT_LO))
				+ (ffls_pkg::NUM_W'(hl_s5) << (ffls_pkg::ROOT_LO + 1))
				+ ffls_pkg::NUM_W'(ll_s5);
			p_sr[0] <= '0;
			q_sr[0] <= '0;
			lvl_sr[0] <= '0;

			for (int j = 0; j < S; j++) begin
				fl_sr[j+1] <= fl_sr[j];
				den_sr[j+1] <= den_sr[j];
				num_sr[j+1] <= num_sr[j];
				if (take[j]) begin
					p_sr[j+1] <= cand[j];
					q_sr[j+1] <= q_sr[j] + dsh[j];
					lvl_sr[j+1] <= lvl_sr[j] | (ffls_pkg::LEVEL_W'(1) << (S - 1 - j));
				end else begin
					p_sr[j+1] <= p_sr[j];
					q_sr[j+1] <= q_sr[j];
					lvl_sr[j+1] <= lvl_sr[j];
				end
			end
		end
	end

	assign shade.valid = vld_sr[S];
	assign shade.shade_level = (fl_sr[S].deg || fl_sr[S].away) ? '0 : lvl_sr[S];
	assign shade.faces_away = fl_sr[S].away;
	assign shade.degenerate = fl_sr[S].deg;
endmodule
`default_nettype wire

// ----- rtl/ffls_checker.sv -----
// port-level checks for the flat lambert shader, bound to the top level
// depends on ffls_pkg and flat_face_lambert_shade
`default_nettype none
module ffls_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [ffls_pkg::LEVEL_W-1:0] shade_level,
	input wire logic                         faces_away,
	input wire logic                         degenerate
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(shade_level)
		&& $stable(faces_away) && $stable(degenerate))
		else $error("result changed while stalled");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipeline stalled");

	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> shade_level == '0 && !faces_away)
		else $error("degenerate result not zero");

	a_away: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && faces_away |-> shade_level == '0)
		else $error("back face result not zero");
endmodule

bind flat_face_lambert_shade ffls_checker u_ffls_checker (
	.clk(clk), .arst_n(arst_n),
	.in_ready(face.ready),
	.out_valid(shade.valid), .out_ready(shade.ready),
	.shade_level(shade.shade_level), .faces_away(shade.faces_away),
	.degenerate(shade.degenerate)
);
`default_nettype wire
